>>> sv/gasp_pkg.sv
`default_nettype none
package gasp_pkg;

  localparam int FUNC_W     = 1;
  localparam int MASK_W     = 6;
  localparam int POS_W      = 12;
  localparam int CELL_W     = 12;
  localparam int KIND_W     = 1;
  localparam int STATUS_W   = 2;
  localparam int COST_W     = 12;
  localparam int COUNT_W    = 13;
  localparam int SIDE_REG_W = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int MOVE_COUNT = 6;
  localparam int MV_W       = 3;

  localparam logic [MV_W-1:0] MV_Y_POS = 3'd0;
  localparam logic [MV_W-1:0] MV_Y_NEG = 3'd1;
  localparam logic [MV_W-1:0] MV_X_POS = 3'd2;
  localparam logic [MV_W-1:0] MV_X_NEG = 3'd3;
  localparam logic [MV_W-1:0] MV_Z_POS = 3'd4;
  localparam logic [MV_W-1:0] MV_Z_NEG = 3'd5;

  localparam logic [FUNC_W-1:0] FN_LOAD = 1'b0;
  localparam logic [FUNC_W-1:0] FN_PATH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_NO_PATH  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BAD_POS  = 2'd3
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SUMMARY = 1'b0,
    KIND_PATH    = 1'b1
  } kind_t;

endpackage
`default_nettype wire

>>> sv/gasp_if.sv
`default_nettype none
interface gasp_in_if;
  logic                          valid;
  logic                          ready;
  logic [gasp_pkg::FUNC_W-1:0]   func;
  logic [gasp_pkg::MASK_W-1:0]   cell_mask;
  logic                          last_cell;
  logic [gasp_pkg::POS_W-1:0]    path_position;
  modport source (output valid, func, cell_mask, last_cell, path_position, input ready);
  modport sink   (input valid, func, cell_mask, last_cell, path_position, output ready);
endinterface

interface gasp_out_if;
  logic                            valid;
  logic                            ready;
  logic [gasp_pkg::KIND_W-1:0]     kind;
  logic [gasp_pkg::STATUS_W-1:0]   status;
  logic [gasp_pkg::COST_W-1:0]     path_cost;
  logic [gasp_pkg::COUNT_W-1:0]    discovered_count;
  logic [gasp_pkg::COUNT_W-1:0]    path_length;
  logic [gasp_pkg::CELL_W-1:0]     path_cell;
  modport source (output valid, kind, status, path_cost, discovered_count, path_length,
                  path_cell, input ready);
  modport sink   (input valid, kind, status, path_cost, discovered_count, path_length,
                  path_cell, output ready);
endinterface

interface gasp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [gasp_pkg::CFG_IDX_W-1:0]    index;
  logic [gasp_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/gasp_ram.sv
`default_nettype none
module gasp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/grid_astar_path_search.sv
// mask load: one word per cycle; path read: the result word is registered in S_PATH_RD and
// S_EMIT, which waits until the previous word is taken; search: product of the sides, flag
// clearing over all CELL_COUNT cells, heap push and pop one level at a time, a check and
// push per neighbor, path walk back and write; single heap memory with one write, two reads
// input is taken only in idle; a second word waits until the first one is taken
// reset (rst, synchronous) clears the handshakes, load pointer, heap count and the summary
`default_nettype none
module grid_astar_path_search #(
  parameter int MAX_SIDE   = 16,
  parameter int CELL_COUNT = 4096,
  parameter int HEAP_DEPTH = 8192
) (
  input logic         clk,
  input logic         rst,
  gasp_in_if.sink     req,
  gasp_out_if.source  rsp,
  gasp_cfg_if.sink    cfg
);

  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int CW   = $clog2(MAX_SIDE);
  localparam int ID_W = $clog2(CELL_COUNT);
  localparam int TW   = 3 * SW;
  localparam int N_W  = ID_W + 1;
  localparam int G_W  = ID_W + 1;
  localparam int H_W  = $clog2(3 * MAX_SIDE);
  localparam int F_W  = G_W + 1;
  localparam int HI_W = $clog2(HEAP_DEPTH);
  localparam int HC_W = HI_W + 1;
  localparam int HL_W = HI_W + 2;

  typedef struct packed {
    logic [F_W-1:0]  f;
    logic [G_W-1:0]  g;
    logic [ID_W-1:0] id;
    logic [CW-1:0]   x;
    logic [CW-1:0]   y;
    logic [CW-1:0]   z;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PATH_RD, S_EMIT, S_MUL1, S_MUL2, S_CLR, S_SEED,
    S_PU0, S_PU1, S_PU2, S_NEXT, S_POP, S_POP1, S_SD0, S_SD1,
    S_CHK, S_CHK2, S_NB, S_NB2, S_PB0, S_PB1, S_PW0, S_PW1
  } state_t;

  function automatic logic [SW-1:0] clamp_side(input logic [gasp_pkg::SIDE_REG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w < 32'd1) return SW'(1);
    if (w > 32'(MAX_SIDE)) return SW'(MAX_SIDE);
    return SW'(w);
  endfunction

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [H_W-1:0] manhattan(input logic [CW-1:0] ax, input logic [CW-1:0] ay,
                                               input logic [CW-1:0] az, input logic [CW-1:0] bx,
                                               input logic [CW-1:0] by, input logic [CW-1:0] bz);
    return H_W'(abs_diff(ax, bx)) + H_W'(abs_diff(ay, by)) + H_W'(abs_diff(az, bz));
  endfunction

  function automatic logic goes_first(input entry_t a, input entry_t b);
    if (a.f != b.f) return a.f < b.f;
    if (a.g != b.g) return a.g > b.g;
    return a.id < b.id;
  endfunction

  // configuration
  logic [gasp_pkg::SIDE_REG_W-1:0] size_x, size_y, size_z;
  logic [gasp_pkg::CELL_W-1:0]     start_cell, target_cell;

  state_t                state;
  logic [ID_W-1:0]       load_ptr;
  logic                  pos_ok;
  gasp_pkg::kind_t       res_kind;
  gasp_pkg::status_t     res_status;
  logic [ID_W-1:0]       res_cell;
  gasp_pkg::status_t     out_status;
  logic [G_W-1:0]        out_cost;
  logic [N_W-1:0]        out_disc, out_len;
  logic [2*SW-1:0]       sxy;
  logic [N_W-1:0]        total;
  logic [ID_W-1:0]       sweep;
  logic [CW-1:0]         cx, cy, cz, stx, sty, stz, tgx, tgy, tgz;
  logic [HC_W-1:0]       hcount;
  logic [HI_W-1:0]       hi;
  entry_t                cur, top, nb;
  logic [G_W-1:0]        cur_g;
  logic [gasp_pkg::MASK_W-1:0] cur_mask;
  logic [gasp_pkg::MV_W-1:0]   mv;
  logic [ID_W-1:0]       pc;
  logic [N_W-1:0]        pn, pk;

  logic [SW-1:0]         sx, sy, sz;
  logic [TW-1:0]         prod;
  logic                  start_bad;
  logic [ID_W-1:0]       start_id, target_id;

  // memories
  logic                  mask_we, best_we, par_we, path_we, flag_we;
  logic [ID_W-1:0]       mask_wa, mask_ra, best_wa, best_ra, par_wa, par_ra;
  logic [ID_W-1:0]       path_wa, path_ra, flag_wa, flag_ra;
  logic [gasp_pkg::MASK_W-1:0] mask_wd, mask_rd;
  logic [G_W-1:0]        best_wd, best_rd;
  logic [ID_W-1:0]       par_wd, par_rd, path_wd, path_rd;
  logic [1:0]            flag_wd, flag_rd;

  entry_t                heap [HEAP_DEPTH];
  logic                  hwe;
  logic [HI_W-1:0]       hwa, hra0, hra1;
  entry_t                hwd, hrd0, hrd1;

  // sift and neighbor logic
  logic [HL_W-1:0]       lch, rch;
  logic [HI_W-1:0]       up;
  logic                  pick_l, pick_r, pu_swap;
  entry_t                sd_ent;
  logic [TW-1:0]         nid_w;
  logic [CW-1:0]         nbx, nby, nbz;
  logic                  in_grid, nb_ok, nb_upd;
  logic [G_W-1:0]        nd;
  entry_t                nb_ent;

  assign sx = clamp_side(size_x);
  assign sy = clamp_side(size_y);
  assign sz = clamp_side(size_z);
  assign prod = TW'(sxy) * TW'(sz);
  assign start_bad = (32'(start_cell) >= 32'(total)) || (32'(target_cell) >= 32'(total));
  assign start_id  = ID_W'(start_cell);
  assign target_id = ID_W'(target_cell);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x      <= gasp_pkg::SIDE_REG_W'(16);
      size_y      <= gasp_pkg::SIDE_REG_W'(16);
      size_z      <= gasp_pkg::SIDE_REG_W'(16);
      start_cell  <= '0;
      target_cell <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        gasp_pkg::REG_SIZE_X: size_x <= cfg.data[gasp_pkg::SIDE_REG_W-1:0];
        gasp_pkg::REG_SIZE_Y: size_y <= cfg.data[gasp_pkg::SIDE_REG_W-1:0];
        gasp_pkg::REG_SIZE_Z: size_z <= cfg.data[gasp_pkg::SIDE_REG_W-1:0];
        gasp_pkg::REG_START:  start_cell <= cfg.data;
        gasp_pkg::REG_TARGET: target_cell <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    lch    = (HL_W'(hi) << 1) + HL_W'(1);
    rch    = lch + HL_W'(1);
    up     = (hi - HI_W'(1)) >> 1;
    pu_swap = goes_first(cur, hrd0);
    pick_l = (lch < HL_W'(hcount)) && goes_first(hrd0, cur);
    sd_ent = pick_l ? hrd0 : cur;
    pick_r = (rch < HL_W'(hcount)) && goes_first(hrd1, sd_ent);
    if (pick_r) begin
      sd_ent = hrd1;
    end
  end

  always_comb begin
    nid_w   = TW'(top.id);
    nbx     = top.x;
    nby     = top.y;
    nbz     = top.z;
    in_grid = 1'b0;
    unique case (mv)
      gasp_pkg::MV_Y_POS: begin
        in_grid = (SW'(top.y) + SW'(1)) < sy;
        nby     = top.y + CW'(1);
        nid_w   = TW'(top.id) + TW'(sx);
      end
      gasp_pkg::MV_Y_NEG: begin
        in_grid = top.y != '0;
        nby     = top.y - CW'(1);
        nid_w   = TW'(top.id) - TW'(sx);
      end
      gasp_pkg::MV_X_POS: begin
        in_grid = (SW'(top.x) + SW'(1)) < sx;
        nbx     = top.x + CW'(1);
        nid_w   = TW'(top.id) + TW'(1);
      end
      gasp_pkg::MV_X_NEG: begin
        in_grid = top.x != '0;
        nbx     = top.x - CW'(1);
        nid_w   = TW'(top.id) - TW'(1);
      end
      gasp_pkg::MV_Z_POS: begin
        in_grid = (SW'(top.z) + SW'(1)) < sz;
        nbz     = top.z + CW'(1);
        nid_w   = TW'(top.id) + TW'(sxy);
      end
      gasp_pkg::MV_Z_NEG: begin
        in_grid = top.z != '0;
        nbz     = top.z - CW'(1);
        nid_w   = TW'(top.id) - TW'(sxy);
      end
      default: in_grid = 1'b0;
    endcase
    nb_ok     = in_grid && cur_mask[mv] && (32'(nid_w) < 32'(total));
    nd        = cur_g + G_W'(1);
    nb_ent.g  = nd;
    nb_ent.f  = F_W'(nd) + F_W'(manhattan(nbx, nby, nbz, tgx, tgy, tgz));
    nb_ent.id = ID_W'(nid_w);
    nb_ent.x  = nbx;
    nb_ent.y  = nby;
    nb_ent.z  = nbz;
    nb_upd    = !flag_rd[0] || (nb.g < best_rd);
  end

  always_comb begin
    mask_we = 1'b0;
    mask_wa = load_ptr;
    mask_wd = req.cell_mask;
    mask_ra = top.id;
    best_we = 1'b0;
    best_wa = nb.id;
    best_wd = nb.g;
    best_ra = top.id;
    par_we  = 1'b0;
    par_wa  = nb.id;
    par_wd  = top.id;
    par_ra  = pc;
    path_we = 1'b0;
    path_wa = ID_W'(pk - N_W'(1));
    path_wd = pc;
    path_ra = ID_W'(req.path_position);
    flag_we = 1'b0;
    flag_wa = top.id;
    flag_wd = {1'b1, flag_rd[0]};
    flag_ra = top.id;
    hwe     = 1'b0;
    hwa     = hi;
    hwd     = cur;
    hra0    = '0;
    hra1    = '0;
    unique case (state)
      S_IDLE: mask_we = req.valid && (req.func == gasp_pkg::FN_LOAD);
      S_CLR: begin
        flag_we = 1'b1;
        flag_wa = sweep;
        flag_wd = 2'b00;
      end
      S_SEED: begin
        flag_we = !start_bad;
        flag_wa = start_id;
        flag_wd = 2'b01;
        best_we = !start_bad;
        best_wa = start_id;
        best_wd = '0;
        par_we  = !start_bad;
        par_wa  = start_id;
        par_wd  = start_id;
      end
      S_PU1: begin
        hwe  = (hi == '0);
        hra0 = up;
      end
      S_PU2: begin
        hwe = 1'b1;
        hwd = pu_swap ? hrd0 : cur;
      end
      S_POP: begin
        hra0 = '0;
        hra1 = HI_W'(hcount - HC_W'(1));
      end
      S_SD0: begin
        hra0 = HI_W'(lch);
        hra1 = HI_W'(rch);
      end
      S_SD1: begin
        hwe = 1'b1;
        hwd = sd_ent;
      end
      S_CHK2: flag_we = !flag_rd[1];
      S_NB: begin
        flag_ra = nb_ent.id;
        best_ra = nb_ent.id;
      end
      S_NB2: begin
        flag_we = !flag_rd[0];
        flag_wa = nb.id;
        flag_wd = {flag_rd[1], 1'b1};
        best_we = nb_upd;
        par_we  = nb_upd;
      end
      S_PW0: path_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hwe) begin
      heap[hwa] <= hwd;
    end
    hrd0 <= heap[hra0];
    hrd1 <= heap[hra1];
  end

  gasp_ram #(.WIDTH(gasp_pkg::MASK_W), .DEPTH(CELL_COUNT)) u_mask_ram (
    .clk(clk), .we(mask_we), .waddr(mask_wa), .wdata(mask_wd), .raddr(mask_ra), .rdata(mask_rd)
  );
  gasp_ram #(.WIDTH(G_W), .DEPTH(CELL_COUNT)) u_best_ram (
    .clk(clk), .we(best_we), .waddr(best_wa), .wdata(best_wd), .raddr(best_ra), .rdata(best_rd)
  );
  gasp_ram #(.WIDTH(ID_W), .DEPTH(CELL_COUNT)) u_parent_ram (
    .clk(clk), .we(par_we), .waddr(par_wa), .wdata(par_wd), .raddr(par_ra), .rdata(par_rd)
  );
  gasp_ram #(.WIDTH(ID_W), .DEPTH(CELL_COUNT)) u_path_ram (
    .clk(clk), .we(path_we), .waddr(path_wa), .wdata(path_wd), .raddr(path_ra), .rdata(path_rd)
  );
  gasp_ram #(.WIDTH(2), .DEPTH(CELL_COUNT)) u_flag_ram (
    .clk(clk), .we(flag_we), .waddr(flag_wa), .wdata(flag_wd), .raddr(flag_ra), .rdata(flag_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      load_ptr   <= '0;
      rsp.valid  <= 1'b0;
      out_status <= gasp_pkg::ST_NO_PATH;
      out_cost   <= '0;
      out_disc   <= '0;
      out_len    <= '0;
      hcount     <= '0;
      res_kind   <= gasp_pkg::KIND_SUMMARY;
    end else begin
      if (rsp.valid && rsp.ready && (state != S_EMIT)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.func == gasp_pkg::FN_LOAD) begin
              if (req.last_cell) begin
                load_ptr <= '0;
                state    <= S_MUL1;
              end else begin
                load_ptr <= (load_ptr == ID_W'(CELL_COUNT - 1)) ? '0 : load_ptr + ID_W'(1);
              end
            end else begin
              pos_ok <= (out_status == gasp_pkg::ST_FOUND)
                        && (32'(req.path_position) < 32'(out_len))
                        && (32'(req.path_position) < 32'(CELL_COUNT));
              state  <= S_PATH_RD;
            end
          end
        end
        S_PATH_RD: begin
          res_kind   <= gasp_pkg::KIND_PATH;
          res_status <= pos_ok ? gasp_pkg::ST_FOUND : gasp_pkg::ST_BAD_POS;
          res_cell   <= pos_ok ? path_rd : '0;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid            <= 1'b1;
            rsp.kind             <= res_kind;
            rsp.status           <= (res_kind == gasp_pkg::KIND_PATH) ? res_status : out_status;
            rsp.path_cost        <= gasp_pkg::COST_W'(out_cost);
            rsp.discovered_count <= gasp_pkg::COUNT_W'(out_disc);
            rsp.path_length      <= gasp_pkg::COUNT_W'(out_len);
            rsp.path_cell        <= (res_kind == gasp_pkg::KIND_PATH)
                                    ? gasp_pkg::CELL_W'(res_cell) : '0;
            state                <= S_IDLE;
          end
        end
        S_MUL1: begin
          sxy        <= (2*SW)'(sx) * (2*SW)'(sy);
          res_kind   <= gasp_pkg::KIND_SUMMARY;
          out_status <= gasp_pkg::ST_NO_PATH;
          out_cost   <= '0;
          out_disc   <= '0;
          out_len    <= '0;
          hcount     <= '0;
          sweep      <= '0;
          cx         <= '0;
          cy         <= '0;
          cz         <= '0;
          state      <= S_MUL2;
        end
        S_MUL2: begin
          total <= (32'(prod) > 32'(CELL_COUNT)) ? N_W'(CELL_COUNT) : N_W'(prod);
          state <= S_CLR;
        end
        S_CLR: begin
          // clear the flags of every cell, tracking coordinates to find start and target
          if (32'(sweep) == 32'(start_cell)) begin
            stx <= cx;
            sty <= cy;
            stz <= cz;
          end
          if (32'(sweep) == 32'(target_cell)) begin
            tgx <= cx;
            tgy <= cy;
            tgz <= cz;
          end
          if ((SW'(cx) + SW'(1)) == sx) begin
            cx <= '0;
            if ((SW'(cy) + SW'(1)) == sy) begin
              cy <= '0;
              cz <= cz + CW'(1);
            end else begin
              cy <= cy + CW'(1);
            end
          end else begin
            cx <= cx + CW'(1);
          end
          sweep <= sweep + ID_W'(1);
          if (sweep == ID_W'(CELL_COUNT - 1)) begin
            state <= S_SEED;
          end
        end
        S_SEED: begin
          if (start_bad) begin
            state <= S_EMIT;
          end else begin
            out_disc <= N_W'(1);
            cur.f    <= F_W'(manhattan(stx, sty, stz, tgx, tgy, tgz));
            cur.g    <= '0;
            cur.id   <= start_id;
            cur.x    <= stx;
            cur.y    <= sty;
            cur.z    <= stz;
            mv       <= gasp_pkg::MV_W'(gasp_pkg::MOVE_COUNT - 1);
            state    <= S_PU0;
          end
        end
        S_PU0: begin
          if (32'(hcount) >= 32'(HEAP_DEPTH)) begin
            out_status <= gasp_pkg::ST_OVERFLOW;
            out_cost   <= '0;
            out_len    <= '0;
            state      <= S_EMIT;
          end else begin
            hi     <= HI_W'(hcount);
            hcount <= hcount + HC_W'(1);
            state  <= S_PU1;
          end
        end
        S_PU1: state <= (hi == '0) ? S_NEXT : S_PU2;
        S_PU2: begin
          if (pu_swap) begin
            hi    <= up;
            state <= S_PU1;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (mv == gasp_pkg::MV_W'(gasp_pkg::MOVE_COUNT - 1)) begin
            state <= S_POP;
          end else begin
            mv    <= mv + gasp_pkg::MV_W'(1);
            state <= S_NB;
          end
        end
        S_POP: state <= (hcount == '0) ? S_EMIT : S_POP1;
        S_POP1: begin
          top    <= hrd0;
          cur    <= hrd1;
          hcount <= hcount - HC_W'(1);
          hi     <= '0;
          state  <= S_SD0;
        end
        S_SD0: state <= S_SD1;
        S_SD1: begin
          priority if (pick_r) begin
            hi    <= HI_W'(rch);
            state <= S_SD0;
          end else if (pick_l) begin
            hi    <= HI_W'(lch);
            state <= S_SD0;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: state <= S_CHK2;
        S_CHK2: begin
          cur_g    <= best_rd;
          cur_mask <= mask_rd;
          if (flag_rd[1]) begin
            state <= S_POP;
          end else if (top.id == target_id) begin
            out_cost <= best_rd;
            pc       <= target_id;
            pn       <= N_W'(1);
            state    <= S_PB0;
          end else begin
            mv    <= '0;
            state <= S_NB;
          end
        end
        S_NB: begin
          nb    <= nb_ent;
          state <= nb_ok ? S_NB2 : S_NEXT;
        end
        S_NB2: begin
          if (!flag_rd[0]) begin
            out_disc <= out_disc + N_W'(1);
          end
          if (nb_upd) begin
            cur   <= nb;
            state <= S_PU0;
          end else begin
            state <= S_NEXT;
          end
        end
        S_PB0: begin
          if ((pc == start_id) || (pn >= total)) begin
            pk    <= pn;
            pc    <= target_id;
            state <= S_PW0;
          end else begin
            state <= S_PB1;
          end
        end
        S_PB1: begin
          pc    <= par_rd;
          pn    <= pn + N_W'(1);
          state <= S_PB0;
        end
        S_PW0: begin
          pk    <= pk - N_W'(1);
          state <= S_PW1;
        end
        S_PW1: begin
          pc <= par_rd;
          if (pk == '0) begin
            out_status <= gasp_pkg::ST_FOUND;
            out_len    <= pn;
            state      <= S_EMIT;
          end else begin
            state <= S_PW0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    32'(hcount) <= 32'(HEAP_DEPTH))
    else $error("heap count past depth");

  a_found_len: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.kind == gasp_pkg::KIND_SUMMARY) && (rsp.status == gasp_pkg::ST_FOUND)
    |-> (rsp.path_length != '0) && (rsp.discovered_count != '0))
    else $error("found summary with empty path");

  a_bad_cell: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.kind == gasp_pkg::KIND_PATH) && (rsp.status != gasp_pkg::ST_FOUND)
    |-> (rsp.path_cell == '0) && (rsp.status == gasp_pkg::ST_BAD_POS))
    else $error("bad path entry carries a cell");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |=> !req.ready)
    else $error("input taken during flag clearing");

endmodule
`default_nettype wire

>>> test/grid_astar_path_search_test.sv
`default_nettype none
module grid_astar_path_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE_MAX = 16;
  localparam int CELLS    = 4096;
  localparam int HEAP_MAX = 8192;

  typedef struct {
    gasp_pkg::kind_t                  kind;
    gasp_pkg::status_t                status;
    logic [gasp_pkg::COST_W-1:0]      cost;
    logic [gasp_pkg::COUNT_W-1:0]     found_cells;
    logic [gasp_pkg::COUNT_W-1:0]     length;
    logic [gasp_pkg::CELL_W-1:0]      path_id;
  } result_word_t;

  logic clk;
  logic rst;

  gasp_in_if  req_if ();
  gasp_out_if rsp_if ();
  gasp_cfg_if cfg_if ();

  grid_astar_path_search DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // search model state
  logic [gasp_pkg::SIDE_REG_W-1:0] side_reg_x, side_reg_y, side_reg_z;
  logic [gasp_pkg::CELL_W-1:0]     start_reg, target_reg;
  logic [gasp_pkg::MASK_W-1:0]     grid_masks [CELLS];
  int unsigned           fill_ptr;
  int unsigned           steps_to [CELLS];
  int unsigned           came_from [CELLS];
  bit                    reached [CELLS];
  bit                    expanded [CELLS];
  int unsigned           route [CELLS];
  int unsigned           open_f [HEAP_MAX];
  int unsigned           open_g [HEAP_MAX];
  int unsigned           open_id [HEAP_MAX];
  int unsigned           open_n;
  gasp_pkg::status_t     last_status;
  int unsigned           last_cost, last_found, last_len;

  result_word_t pending_words[$];
  int           errors;
  bit           calm;
  int           hold_len;

  function automatic int unsigned clamp_side(int unsigned v);
    if (v < 1) return 1;
    if (v > SIDE_MAX) return SIDE_MAX;
    return v;
  endfunction

  function automatic bit ahead(int unsigned fa, int unsigned ga, int unsigned ia,
                               int unsigned fb, int unsigned gb, int unsigned ib);
    if (fa != fb) return fa < fb;
    if (ga != gb) return ga > gb;
    return ia < ib;
  endfunction

  function automatic void swap_open(int unsigned a, int unsigned b);
    int unsigned t;
    t = open_f[a]; open_f[a] = open_f[b]; open_f[b] = t;
    t = open_g[a]; open_g[a] = open_g[b]; open_g[b] = t;
    t = open_id[a]; open_id[a] = open_id[b]; open_id[b] = t;
  endfunction

  function automatic bit open_push(int unsigned f, int unsigned g, int unsigned id);
    int unsigned i, up;
    if (open_n >= HEAP_MAX) return 0;
    i = open_n;
    open_n++;
    open_f[i] = f; open_g[i] = g; open_id[i] = id;
    while (i > 0) begin
      up = (i - 1) / 2;
      if (!ahead(open_f[i], open_g[i], open_id[i], open_f[up], open_g[up], open_id[up]))
        break;
      swap_open(i, up);
      i = up;
    end
    return 1;
  endfunction

  function automatic int unsigned open_pop();
    int unsigned top, i, l, r, m;
    top = open_id[0];
    i = 0;
    open_n--;
    open_f[0] = open_f[open_n]; open_g[0] = open_g[open_n]; open_id[0] = open_id[open_n];
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < open_n && ahead(open_f[l], open_g[l], open_id[l], open_f[m], open_g[m],
                              open_id[m])) m = l;
      if (r < open_n && ahead(open_f[r], open_g[r], open_id[r], open_f[m], open_g[m],
                              open_id[m])) m = r;
      if (m == i) break;
      swap_open(i, m);
      i = m;
    end
    return top;
  endfunction

  function automatic int unsigned span(int unsigned a, int unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic int unsigned grid_cells();
    int unsigned t;
    t = clamp_side(side_reg_x) * clamp_side(side_reg_y) * clamp_side(side_reg_z);
    return t > CELLS ? CELLS : t;
  endfunction

  function automatic void solve_grid();
    int unsigned sx, sy, sz, total, st, tg, tx, ty, tz, id, g, x, y, z, nid, nd, h, n, c;
    int nx, ny, nz;
    logic [gasp_pkg::MASK_W-1:0] m;
    sx = clamp_side(side_reg_x);
    sy = clamp_side(side_reg_y);
    sz = clamp_side(side_reg_z);
    total = grid_cells();
    st = start_reg;
    tg = target_reg;
    for (int k = 0; k < CELLS; k++) begin
      reached[k] = 0;
      expanded[k] = 0;
    end
    open_n = 0;
    last_status = gasp_pkg::ST_NO_PATH;
    last_cost = 0; last_found = 0; last_len = 0;
    if (st >= total || tg >= total) return;
    tx = tg % sx; ty = (tg / sx) % sy; tz = tg / (sx * sy);
    reached[st] = 1;
    steps_to[st] = 0;
    came_from[st] = st;
    last_found = 1;
    x = st % sx; y = (st / sx) % sy; z = st / (sx * sy);
    void'(open_push(span(x, tx) + span(y, ty) + span(z, tz), 0, st));
    forever begin
      do begin
        if (open_n == 0) begin
          last_status = gasp_pkg::ST_NO_PATH;
          return;
        end
        id = open_pop();
      end while (expanded[id]);
      expanded[id] = 1;
      if (id == tg) begin
        n = 1;
        c = tg;
        while (c != st && n < total) begin
          c = came_from[c];
          n++;
        end
        c = tg;
        for (int k = n; k > 0; k--) begin
          route[k - 1] = c;
          c = came_from[c];
        end
        last_status = gasp_pkg::ST_FOUND;
        last_cost = steps_to[tg];
        last_len = n;
        return;
      end
      g = steps_to[id];
      m = grid_masks[id];
      x = id % sx; y = (id / sx) % sy; z = id / (sx * sy);
      for (int i = 0; i < gasp_pkg::MOVE_COUNT; i++) begin
        if (!m[i]) continue;
        nx = x; ny = y; nz = z;
        case (i)
          gasp_pkg::MV_Y_POS: ny++;
          gasp_pkg::MV_Y_NEG: ny--;
          gasp_pkg::MV_X_POS: nx++;
          gasp_pkg::MV_X_NEG: nx--;
          gasp_pkg::MV_Z_POS: nz++;
          default:  nz--;
        endcase
        if (nx < 0 || ny < 0 || nz < 0) continue;
        if (nx >= sx || ny >= sy || nz >= sz) continue;
        nid = nx + sx * (ny + sy * nz);
        if (nid >= total) continue;
        nd = g + 1;
        h = span(nx, tx) + span(ny, ty) + span(nz, tz);
        if (!reached[nid]) begin
          reached[nid] = 1;
          last_found++;
        end else if (nd >= steps_to[nid]) begin
          continue;
        end
        steps_to[nid] = nd;
        came_from[nid] = id;
        if (!open_push(nd + h, nd, nid)) begin
          last_status = gasp_pkg::ST_OVERFLOW;
          last_cost = 0;
          last_len = 0;
          return;
        end
      end
    end
  endfunction

  function automatic void predict_word(logic [gasp_pkg::FUNC_W-1:0] fn,
                                       logic [gasp_pkg::MASK_W-1:0] mask,
                                       logic last, logic [gasp_pkg::POS_W-1:0] pos);
    result_word_t w;
    bit ok;
    if (fn == gasp_pkg::FN_LOAD) begin
      grid_masks[fill_ptr] = mask;
      fill_ptr = (fill_ptr + 1) % CELLS;
      if (!last) return;
      fill_ptr = 0;
      solve_grid();
      w.kind = gasp_pkg::KIND_SUMMARY;
      w.status = last_status;
      w.path_id = '0;
    end else begin
      ok = last_status == gasp_pkg::ST_FOUND && pos < last_len;
      w.kind = gasp_pkg::KIND_PATH;
      w.status = ok ? gasp_pkg::ST_FOUND : gasp_pkg::ST_BAD_POS;
      w.path_id = ok ? gasp_pkg::CELL_W'(route[pos]) : '0;
    end
    w.cost = gasp_pkg::COST_W'(last_cost);
    w.found_cells = gasp_pkg::COUNT_W'(last_found);
    w.length = gasp_pkg::COUNT_W'(last_len);
    pending_words = {pending_words, w};
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  // result word checker
  always @(posedge clk) begin
    result_word_t w;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_words.size() == 0) begin
        flag_mismatch("unexpected word kind", rsp_if.kind, -1);
      end else begin
        w = pending_words.pop_front();
        if (rsp_if.kind !== w.kind) flag_mismatch("kind", rsp_if.kind, w.kind);
        if (rsp_if.status !== w.status) flag_mismatch("status", rsp_if.status, w.status);
        if (rsp_if.path_cost !== w.cost) flag_mismatch("path_cost", rsp_if.path_cost, w.cost);
        if (rsp_if.discovered_count !== w.found_cells)
          flag_mismatch("discovered_count", rsp_if.discovered_count, w.found_cells);
        if (rsp_if.path_length !== w.length)
          flag_mismatch("path_length", rsp_if.path_length, w.length);
        if (rsp_if.path_cell !== w.path_id)
          flag_mismatch("path_cell", rsp_if.path_cell, w.path_id);
      end
    end
  end

  // receiver
  initial begin
    int n;
    rsp_if.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_len > 0) begin
        rsp_if.ready = 0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      n = draw_gap();
      if (n > 0) begin
        rsp_if.ready = 0;
        repeat (n) @(negedge clk);
      end
      rsp_if.ready = 1;
      do @(posedge clk); while (!rsp_if.valid && hold_len == 0);
      @(negedge clk);
    end
  end

  task automatic offer_request(logic [gasp_pkg::FUNC_W-1:0] fn,
                               logic [gasp_pkg::MASK_W-1:0] mask, logic last,
                               logic [gasp_pkg::POS_W-1:0] pos);
    int n;
    n = draw_gap();
    if (n > 0) begin
      req_if.valid = 0;
      repeat (n) @(negedge clk);
    end
    req_if.valid = 1;
    req_if.func = fn;
    req_if.cell_mask = mask;
    req_if.last_cell = last;
    req_if.path_position = pos;
    do @(posedge clk); while (!req_if.ready);
    predict_word(fn, mask, last, pos);
    @(negedge clk);
    req_if.valid = 0;
  endtask

  task automatic offer_read(int pos);
    offer_request(gasp_pkg::FN_PATH, gasp_pkg::MASK_W'($urandom), 1'($urandom),
                  gasp_pkg::POS_W'(pos));
  endtask

  task automatic write_reg(logic [gasp_pkg::CFG_IDX_W-1:0] idx,
                           logic [gasp_pkg::CFG_DATA_W-1:0] data);
    req_if.valid = 0;
    cfg_if.valid = 1;
    cfg_if.index = idx;
    cfg_if.data = data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      gasp_pkg::REG_SIZE_X: side_reg_x = data[gasp_pkg::SIDE_REG_W-1:0];
      gasp_pkg::REG_SIZE_Y: side_reg_y = data[gasp_pkg::SIDE_REG_W-1:0];
      gasp_pkg::REG_SIZE_Z: side_reg_z = data[gasp_pkg::SIDE_REG_W-1:0];
      gasp_pkg::REG_START:  start_reg = data;
      gasp_pkg::REG_TARGET: target_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 0;
  endtask

  task automatic drain();
    req_if.valid = 0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_grid(int sx, int sy, int sz, int st, int tg);
    drain();
    write_reg(gasp_pkg::REG_SIZE_X, {7'($urandom_range(0, 127)), sx[4:0]});
    write_reg(gasp_pkg::REG_SIZE_Y, {7'($urandom_range(0, 127)), sy[4:0]});
    write_reg(gasp_pkg::REG_SIZE_Z, {7'($urandom_range(0, 127)), sz[4:0]});
    write_reg(gasp_pkg::REG_START, st[11:0]);
    write_reg(gasp_pkg::REG_TARGET, tg[11:0]);
  endtask

  // load every cell in use, pct is the chance of each move bit
  task automatic load_grid(int pct, bit stray_reads);
    int total;
    logic [gasp_pkg::MASK_W-1:0] m;
    total = grid_cells();
    for (int k = 0; k < total; k++) begin
      for (int b = 0; b < gasp_pkg::MASK_W; b++) m[b] = $urandom_range(0, 99) < pct;
      if (stray_reads && $urandom_range(0, 7) == 0)
        offer_read($urandom);
      offer_request(gasp_pkg::FN_LOAD, m, k == total - 1, gasp_pkg::POS_W'($urandom));
    end
  endtask

  task automatic read_route(int extra);
    int lim;
    lim = last_len > 12 ? 12 : last_len;
    for (int p = 0; p <= lim; p++) offer_read(p);
    if (last_len > 0) offer_read(last_len - 1);
    for (int k = 0; k < extra; k++) offer_read($urandom);
  endtask

  task automatic test_reads_after_reset();
    offer_request(gasp_pkg::FN_PATH, 6'h3f, 1'b1, 12'd0);
    offer_request(gasp_pkg::FN_PATH, 6'h00, 1'b0, 12'hfff);
  endtask

  task automatic test_directed();
    set_grid(2, 2, 1, 0, 3);
    load_grid(100, 0);
    read_route(0);
    offer_request(gasp_pkg::FN_PATH, 6'h15, 1'b0, 12'hfff);
    set_grid(3, 1, 1, 1, 1);
    load_grid(100, 0);
    read_route(0);
    set_grid(2, 2, 2, 0, 4095);
    load_grid(100, 0);
    offer_request(gasp_pkg::FN_PATH, 6'h2a, 1'b1, 12'd0);
    set_grid(0, 0, 0, 0, 0);
    load_grid(0, 0);
    read_route(0);
    set_grid(2, 2, 1, 0, 3);
    load_grid(0, 0);
    read_route(0);
  endtask

  task automatic test_largest_grid();
    calm = 1;
    set_grid(31, 16, 1, 0, 255);
    load_grid(90, 0);
    read_route(2);
    calm = 0;
  endtask

  task automatic test_random_searches();
    int sx, sy, sz, total, st, tg;
    for (int r = 0; r < 10; r++) begin
      sx = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 4);
      sy = $urandom_range(1, 4);
      sz = $urandom_range(0, 9) == 0 ? 17 : $urandom_range(1, 3);
      if (sz == 17) sx = 1;
      total = clamp_side(sx) * clamp_side(sy) * clamp_side(sz);
      st = $urandom_range(0, total - 1);
      tg = $urandom_range(0, total - 1);
      if ($urandom_range(0, 11) == 0) st = $urandom_range(0, 4095);
      if ($urandom_range(0, 11) == 0) tg = $urandom_range(0, 4095);
      calm = $urandom_range(0, 3) == 0;
      set_grid(sx, sy, sz, st, tg);
      load_grid($urandom_range(50, 95), $urandom_range(0, 3) == 0);
      read_route($urandom_range(0, 2));
    end
    calm = 0;
  endtask

  task automatic test_stalled_receiver();
    set_grid(4, 4, 1, 0, 15);
    load_grid(100, 0);
    drain();
    hold_len = 300;
    for (int k = 0; k < 24; k++) offer_read(k % 8);
    drain();
  endtask

  initial begin
    errors = 0;
    calm = 0;
    hold_len = 0;
    side_reg_x = 16; side_reg_y = 16; side_reg_z = 16;
    start_reg = 0; target_reg = 0;
    fill_ptr = 0;
    last_status = gasp_pkg::ST_NO_PATH;
    last_cost = 0; last_found = 0; last_len = 0;
    rst = 1;
    req_if.valid = 0;
    req_if.func = gasp_pkg::FN_LOAD;
    req_if.cell_mask = '0;
    req_if.last_cell = 0;
    req_if.path_position = '0;
    cfg_if.valid = 0;
    cfg_if.index = gasp_pkg::REG_SIZE_X;
    cfg_if.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_reads_after_reset();
    test_directed();
    test_stalled_receiver();
    test_random_searches();
    test_largest_grid();
    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
